// File: design/rslp_pkg.sv
`default_nettype none

package rslp_pkg;

   localparam int unsigned COORD_BITS_DEFAULT = 16;

   typedef enum logic [2:0] {
      KEPT_NONE   = 3'd0,
      KEPT_TOP    = 3'd1,
      KEPT_BOTTOM = 3'd2,
      KEPT_LEFT   = 3'd3,
      KEPT_RIGHT  = 3'd4,
      KEPT_EMPTY  = 3'd5
   } kept_type;

   typedef enum logic [1:0] {
      SIDE_TOP    = 2'd0,
      SIDE_BOTTOM = 2'd1,
      SIDE_LEFT   = 2'd2,
      SIDE_RIGHT  = 2'd3
   } side_type;

endpackage

`default_nettype wire

// File: design/rect_subtract_largest_part.sv
`default_nettype none

// Channel  Handshake              Word
// req      req_valid/req_ready    rectangles A and B (left, top, width, height)
// rsp      rsp_valid/rsp_ready    kept strip (left, top, width, height) and kept part
//
// One word is accepted per cycle while the output is not stalled; a result leaves through the stages below.
// The five register stages are edge sums, edge compares, the four area
// multipliers, the pairwise area select and the final select with the output register.
// Each stage advances when it is empty or when the stage after it advances,
// so a stalled output fills bubbles before req_ready drops.
// The synchronous reset clears all stage valid bits.

module rect_subtract_largest_part import rslp_pkg::*; #(
   parameter int unsigned COORD_BITS = COORD_BITS_DEFAULT
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic signed [COORD_BITS-1:0] req_a_left,
   input  wire logic signed [COORD_BITS-1:0] req_a_top,
   input  wire logic        [COORD_BITS-2:0] req_a_width,
   input  wire logic        [COORD_BITS-2:0] req_a_height,
   input  wire logic signed [COORD_BITS-1:0] req_b_left,
   input  wire logic signed [COORD_BITS-1:0] req_b_top,
   input  wire logic        [COORD_BITS-2:0] req_b_width,
   input  wire logic        [COORD_BITS-2:0] req_b_height,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic signed [COORD_BITS:0]        rsp_out_left,
   output logic signed [COORD_BITS:0]        rsp_out_top,
   output logic        [COORD_BITS-2:0]      rsp_out_width,
   output logic        [COORD_BITS-2:0]      rsp_out_height,
   output logic        [2:0]                 rsp_kept_part
);

   localparam int unsigned CW = COORD_BITS;
   localparam int unsigned WW = COORD_BITS - 1;
   localparam int unsigned EW = COORD_BITS + 1;
   localparam int unsigned AW = 2 * (COORD_BITS - 1);

   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic en1, en2, en3, en4, en5;

   // Stage 1: sign-extended corners and far edges.
   logic signed [EW-1:0] al1_ff, at1_ff, bl1_ff, bt1_ff;
   logic signed [EW-1:0] ar1_ff, ab1_ff, br1_ff, bb1_ff;
   logic signed [EW-1:0] ar1_in, ab1_in, br1_in, bb1_in;
   logic [WW-1:0]        aw1_ff, ah1_ff;

   // Stage 2: overlap test, candidates and strip sizes.
   logic                 nov2_ff, nov2_in;
   logic [3:0]           cand2_ff, cand2_in;
   logic [WW-1:0]        size2_ff [4];
   logic [WW-1:0]        size2_in [4];
   logic signed [EW-1:0] al2_ff, at2_ff, br2_ff, bb2_ff;
   logic [WW-1:0]        aw2_ff, ah2_ff;

   // Stage 3: areas.
   logic [AW-1:0]        area3_ff [4];
   logic [AW-1:0]        area3_in [4];
   logic                 tbfirst3_ff, lrfirst3_ff;
   logic                 nov3_ff;
   logic [3:0]           cand3_ff;
   logic [WW-1:0]        size3_ff [4];
   logic signed [EW-1:0] al3_ff, at3_ff, br3_ff, bb3_ff;
   logic [WW-1:0]        aw3_ff, ah3_ff;

   // Stage 4: winners of the top/bottom pair and the left/right pair.
   logic                 sel01_ff, sel01_in, sel23_ff, sel23_in;
   logic [AW-1:0]        a01_ff, a01_in, a23_ff, a23_in;
   logic                 tbfirst4_ff, lrfirst4_ff;
   logic                 nov4_ff;
   logic [3:0]           cand4_ff;
   logic [WW-1:0]        size4_ff [4];
   logic signed [EW-1:0] al4_ff, at4_ff, br4_ff, bb4_ff;
   logic [WW-1:0]        aw4_ff, ah4_ff;

   // Stage 5: output register.
   logic signed [EW-1:0] left5_ff, left5_in, top5_ff, top5_in;
   logic [WW-1:0]        wid5_ff, wid5_in, hgt5_ff, hgt5_in;
   kept_type             kept5_ff, kept5_in;
   side_type             best;
   logic                 found;
   logic                 any01, any23;

   assign en5       = !v5_ff || rsp_ready;
   assign en4       = !v4_ff || en5;
   assign en3       = !v3_ff || en4;
   assign en2       = !v2_ff || en3;
   assign en1       = !v1_ff || en2;
   assign req_ready = en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= req_valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
         if (en5) v5_ff <= v4_ff;
      end
   end

   always_comb begin
      ar1_in = {req_a_left[CW-1], req_a_left} + {2'b00, req_a_width};
      ab1_in = {req_a_top[CW-1], req_a_top} + {2'b00, req_a_height};
      br1_in = {req_b_left[CW-1], req_b_left} + {2'b00, req_b_width};
      bb1_in = {req_b_top[CW-1], req_b_top} + {2'b00, req_b_height};
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         al1_ff <= {req_a_left[CW-1], req_a_left};
         at1_ff <= {req_a_top[CW-1], req_a_top};
         bl1_ff <= {req_b_left[CW-1], req_b_left};
         bt1_ff <= {req_b_top[CW-1], req_b_top};
         aw1_ff <= req_a_width;
         ah1_ff <= req_a_height;
         ar1_ff <= ar1_in;
         ab1_ff <= ab1_in;
         br1_ff <= br1_in;
         bb1_ff <= bb1_in;
      end
   end

   always_comb begin
      nov2_in = (br1_ff <= al1_ff) || (bb1_ff <= at1_ff) ||
                (bl1_ff >= ar1_ff) || (bt1_ff >= ab1_ff);
      cand2_in[SIDE_TOP]    = (bt1_ff > at1_ff) && (bt1_ff < ab1_ff);
      cand2_in[SIDE_BOTTOM] = (bb1_ff > at1_ff) && (bb1_ff < ab1_ff);
      cand2_in[SIDE_LEFT]   = (bl1_ff > al1_ff) && (bl1_ff < ar1_ff);
      cand2_in[SIDE_RIGHT]  = (br1_ff > al1_ff) && (br1_ff < ar1_ff);
      size2_in[SIDE_TOP]    = WW'(bt1_ff - at1_ff);
      size2_in[SIDE_BOTTOM] = WW'(ab1_ff - bb1_ff);
      size2_in[SIDE_LEFT]   = WW'(bl1_ff - al1_ff);
      size2_in[SIDE_RIGHT]  = WW'(ar1_ff - br1_ff);
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         nov2_ff  <= nov2_in;
         cand2_ff <= cand2_in;
         size2_ff <= size2_in;
         al2_ff   <= al1_ff;
         at2_ff   <= at1_ff;
         br2_ff   <= br1_ff;
         bb2_ff   <= bb1_ff;
         aw2_ff   <= aw1_ff;
         ah2_ff   <= ah1_ff;
      end
   end

   always_comb begin
      area3_in[SIDE_TOP]    = AW'(aw2_ff) * AW'(size2_ff[SIDE_TOP]);
      area3_in[SIDE_BOTTOM] = AW'(aw2_ff) * AW'(size2_ff[SIDE_BOTTOM]);
      area3_in[SIDE_LEFT]   = AW'(size2_ff[SIDE_LEFT]) * AW'(ah2_ff);
      area3_in[SIDE_RIGHT]  = AW'(size2_ff[SIDE_RIGHT]) * AW'(ah2_ff);
   end

   always_ff @(posedge clock) begin
      if (en3) begin
         area3_ff    <= area3_in;
         tbfirst3_ff <= size2_ff[SIDE_TOP] > size2_ff[SIDE_BOTTOM];
         lrfirst3_ff <= size2_ff[SIDE_LEFT] > size2_ff[SIDE_RIGHT];
         nov3_ff     <= nov2_ff;
         cand3_ff    <= cand2_ff;
         size3_ff    <= size2_ff;
         al3_ff      <= al2_ff;
         at3_ff      <= at2_ff;
         br3_ff      <= br2_ff;
         bb3_ff      <= bb2_ff;
         aw3_ff      <= aw2_ff;
         ah3_ff      <= ah2_ff;
      end
   end

   // Within each pair the later strip wins unless the earlier one is strictly larger.
   always_comb begin
      sel01_in = cand3_ff[SIDE_BOTTOM] &&
                 !(cand3_ff[SIDE_TOP] && (area3_ff[SIDE_TOP] > area3_ff[SIDE_BOTTOM]));
      sel23_in = cand3_ff[SIDE_RIGHT] &&
                 !(cand3_ff[SIDE_LEFT] && (area3_ff[SIDE_LEFT] > area3_ff[SIDE_RIGHT]));
      a01_in   = sel01_in ? area3_ff[SIDE_BOTTOM] : area3_ff[SIDE_TOP];
      a23_in   = sel23_in ? area3_ff[SIDE_RIGHT] : area3_ff[SIDE_LEFT];
   end

   always_ff @(posedge clock) begin
      if (en4) begin
         sel01_ff    <= sel01_in;
         sel23_ff    <= sel23_in;
         a01_ff      <= a01_in;
         a23_ff      <= a23_in;
         tbfirst4_ff <= tbfirst3_ff;
         lrfirst4_ff <= lrfirst3_ff;
         nov4_ff     <= nov3_ff;
         cand4_ff    <= cand3_ff;
         size4_ff    <= size3_ff;
         al4_ff      <= al3_ff;
         at4_ff      <= at3_ff;
         br4_ff      <= br3_ff;
         bb4_ff      <= bb3_ff;
         aw4_ff      <= aw3_ff;
         ah4_ff      <= ah3_ff;
      end
   end

   // When only the two horizontal or only the two vertical strips qualify,
   // their sizes decide rather than their areas.
   always_comb begin
      any01 = cand4_ff[SIDE_TOP] || cand4_ff[SIDE_BOTTOM];
      any23 = cand4_ff[SIDE_LEFT] || cand4_ff[SIDE_RIGHT];
      found = 1'b1;
      best  = SIDE_TOP;
      if (cand4_ff == 4'b0011) begin
         best = tbfirst4_ff ? SIDE_TOP : SIDE_BOTTOM;
      end else if (cand4_ff == 4'b1100) begin
         best = lrfirst4_ff ? SIDE_LEFT : SIDE_RIGHT;
      end else if (any01 && any23) begin
         if (a01_ff > a23_ff) begin
            best = side_type'({1'b0, sel01_ff});
         end else begin
            best = side_type'({1'b1, sel23_ff});
         end
      end else if (any01) begin
         best = side_type'({1'b0, sel01_ff});
      end else if (any23) begin
         best = side_type'({1'b1, sel23_ff});
      end else begin
         found = 1'b0;
      end
   end

   always_comb begin
      left5_in = al4_ff;
      top5_in  = at4_ff;
      wid5_in  = aw4_ff;
      hgt5_in  = ah4_ff;
      kept5_in = KEPT_NONE;
      if (!nov4_ff) begin
         if (!found) begin
            wid5_in  = '0;
            hgt5_in  = '0;
            kept5_in = KEPT_EMPTY;
         end else begin
            case (best)
               SIDE_TOP: begin
                  hgt5_in  = size4_ff[SIDE_TOP];
                  kept5_in = KEPT_TOP;
               end
               SIDE_BOTTOM: begin
                  top5_in  = bb4_ff;
                  hgt5_in  = size4_ff[SIDE_BOTTOM];
                  kept5_in = KEPT_BOTTOM;
               end
               SIDE_LEFT: begin
                  wid5_in  = size4_ff[SIDE_LEFT];
                  kept5_in = KEPT_LEFT;
               end
               SIDE_RIGHT: begin
                  left5_in = br4_ff;
                  wid5_in  = size4_ff[SIDE_RIGHT];
                  kept5_in = KEPT_RIGHT;
               end
               default: begin
                  kept5_in = KEPT_EMPTY;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en5) begin
         left5_ff <= left5_in;
         top5_ff  <= top5_in;
         wid5_ff  <= wid5_in;
         hgt5_ff  <= hgt5_in;
         kept5_ff <= kept5_in;
      end
   end

   assign rsp_valid      = v5_ff;
   assign rsp_out_left   = left5_ff;
   assign rsp_out_top    = top5_ff;
   assign rsp_out_width  = wid5_ff;
   assign rsp_out_height = hgt5_ff;
   assign rsp_kept_part  = kept5_ff;

endmodule

`default_nettype wire

// File: design/rslp_check.sv
`default_nettype none

module rslp_check import rslp_pkg::*; #(
   parameter int unsigned COORD_BITS = COORD_BITS_DEFAULT
) (
   input wire logic                    clock,
   input wire logic                    reset,
   input wire logic                    rsp_valid,
   input wire logic                    rsp_ready,
   input wire logic [COORD_BITS-2:0]   rsp_out_width,
   input wire logic [COORD_BITS-2:0]   rsp_out_height,
   input wire logic [2:0]              rsp_kept_part
);

   // rsp_valid stays high until the word is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp word dropped while stalled");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid set right after reset");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kept_part == KEPT_EMPTY |->
         rsp_out_width == '0 && rsp_out_height == '0)
      else $error("empty result with nonzero size");

   // A side strip exists only when B's edge lies strictly inside A.
   a_side_width: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kept_part == KEPT_LEFT || rsp_kept_part == KEPT_RIGHT) |->
         rsp_out_width != '0)
      else $error("left or right strip with zero width");

   a_strip_height: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kept_part == KEPT_TOP || rsp_kept_part == KEPT_BOTTOM) |->
         rsp_out_height != '0)
      else $error("top or bottom strip with zero height");

endmodule

bind rect_subtract_largest_part rslp_check #(.COORD_BITS(COORD_BITS)) u_rslp_check (.*);

`default_nettype wire
